>>> hdl/cbd_pkg.sv
// cbd_pkg: shared codes, address map and widths for the console bus decoder
// no dependencies; imported by the channel interfaces, the core and the checker
package cbd_pkg;

    // input word kinds
    localparam logic [2:0] KIND_READ    = 3'd0;
    localparam logic [2:0] KIND_WRITE   = 3'd1;
    localparam logic [2:0] KIND_BUTTONS = 3'd2;
    localparam logic [2:0] KIND_CYCLES  = 3'd3;
    localparam logic [2:0] KIND_DMA     = 3'd4;

    // result regions
    localparam logic [2:0] REGION_INTERNAL = 3'd0;
    localparam logic [2:0] REGION_PPU      = 3'd1;
    localparam logic [2:0] REGION_APU      = 3'd2;
    localparam logic [2:0] REGION_CART     = 3'd3;
    localparam logic [2:0] REGION_NONE     = 3'd4;

    // bus address map
    localparam logic [15:0] ADDR_PPU_BASE   = 16'h2000;
    localparam logic [15:0] ADDR_IO_BASE    = 16'h4000;
    localparam logic [15:0] ADDR_OAM_DMA    = 16'h4014;
    localparam logic [15:0] ADDR_APU_STATUS = 16'h4015;
    localparam logic [15:0] ADDR_JOY1       = 16'h4016;
    localparam logic [15:0] ADDR_JOY2       = 16'h4017;
    localparam logic [15:0] ADDR_IO_TEST    = 16'h4018;
    localparam logic [15:0] ADDR_CART_BASE  = 16'h4020;

    // work ram: 2 KiB mirrored below the ppu window
    localparam int RAM_AW    = 11;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    // sprite dma length in counted cycles, extended by the parity bit on odd parity
    localparam int          DMA_CNT_W = 10;
    localparam logic [9:0]  DMA_LEN   = 10'd513;

endpackage

>>> hdl/cbd_if.sv
// cbd_req_if / cbd_rsp_if: valid-ready channels of the console bus decoder
// depends on cbd_pkg for the kind and region codes
interface cbd_req_if
    import cbd_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        port;
    logic [3:0]  cycles;

    modport source (output valid, kind, address, data, port, cycles, input ready);
    modport sink   (input valid, kind, address, data, port, cycles, output ready);
endinterface

interface cbd_rsp_if
    import cbd_pkg::*;
;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [2:0]  region;
    logic [15:0] fwd_addr;
    logic        fwd_write;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic        dma_busy;

    modport source (output valid, read_data, region, fwd_addr, fwd_write, oam_write,
                    oam_index, dma_busy, input ready);
    modport sink   (input valid, read_data, region, fwd_addr, fwd_write, oam_write,
                    oam_index, dma_busy, output ready);
endinterface

>>> hdl/console_cpu_bus_decoder_dma_core.sv
// console_cpu_bus_decoder_dma_core: cpu bus decode, work ram, controller ports, sprite dma
// depends on cbd_pkg and the channel interfaces in cbd_if.sv
//
// usage
//   req carries one bus word per cpu clock while ready is high: a read, a write, a button update,
//   a count of cpu cycles (parity only) or one sprite dma cycle.
//   rsp returns exactly one word per request: ram byte or controller bit,
//   the region the access went to, the forwarded address and write flag,
//   the sprite memory write strobe and index, and whether dma is still busy.
// response and throughput
//   a request is decoded in the cycle it is accepted; the response word is
//   loaded into the output register at the accepting edge. the ram read data
//   arrives from the synchronous 2 KiB ram at that same edge, and a new request
//   is taken every cycle (one word per clock) while rsp is not stalled.
// reset
//   rst_n clears all control state, then a clearing pass writes zero to the
//   2048 ram entries, one per cycle; req.ready stays low until the pass ends
//   and the block starts taking words afterwards.
// stalls
//   when rsp.ready is low with a word waiting, the response word holds and req.ready drops; the
//   ram read register only loads on an accepted request, so it holds too.
module console_cpu_bus_decoder_dma_core
    import cbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    cbd_req_if.sink    req,
    cbd_rsp_if.source  rsp
);

    // ram clearing pass after reset
    logic              clr_busy_reg;
    logic [RAM_AW-1:0] clr_addr_reg;

    // controller and dma state
    logic [7:0]           buttons0_reg, buttons0_next;
    logic [7:0]           buttons1_reg, buttons1_next;
    logic [7:0]           shift0_reg, shift0_next;
    logic [7:0]           shift1_reg, shift1_next;
    logic                 strobe_reg, strobe_next;
    logic                 dma_on_reg, dma_on_next;
    logic [7:0]           src_page_reg, src_page_next;
    logic [7:0]           dma_index_reg, dma_index_next;
    logic [DMA_CNT_W-1:0] dma_count_reg, dma_count_next;
    logic                 parity_reg, parity_next;

    // response register
    logic        out_valid_reg;
    logic [7:0]  rd_reg, rd_next;
    logic        sel_ram_reg, sel_ram_next;
    logic [2:0]  region_reg, region_next;
    logic [15:0] fwd_addr_reg, fwd_addr_next;
    logic        fwd_write_reg, fwd_write_next;
    logic        oam_write_reg, oam_write_next;
    logic [7:0]  oam_index_reg, oam_index_next;
    logic        busy_reg;

    // work ram
    logic [7:0]        ram [RAM_DEPTH];
    logic [7:0]        ram_q_reg;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_wa;
    logic [7:0]        ram_wd;
    logic              ram_re;

    logic              accept;
    logic              do_read;
    logic [15:0]       rd_addr;
    logic [DMA_CNT_W-1:0] cnt_dec;

    // a new word is taken only when the output register is empty or its word leaves in that cycle
    assign req.ready = !clr_busy_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign cnt_dec = dma_count_reg - {{(DMA_CNT_W-1){1'b0}}, 1'b1};

    // next-state decode; every controller and dma state update happens at the accepting edge
    always_comb
    begin
        buttons0_next  = buttons0_reg;
        buttons1_next  = buttons1_reg;
        shift0_next    = shift0_reg;
        shift1_next    = shift1_reg;
        strobe_next    = strobe_reg;
        dma_on_next    = dma_on_reg;
        src_page_next  = src_page_reg;
        dma_index_next = dma_index_reg;
        dma_count_next = dma_count_reg;
        parity_next    = parity_reg;

        rd_next        = 8'd0;
        sel_ram_next   = 1'b0;
        region_next    = REGION_NONE;
        fwd_addr_next  = 16'd0;
        fwd_write_next = 1'b0;
        oam_write_next = 1'b0;
        oam_index_next = 8'd0;

        do_read = 1'b0;
        rd_addr = req.address;
        ram_we  = 1'b0;
        ram_wa  = req.address[RAM_AW-1:0];
        ram_wd  = req.data;

        case (req.kind)
            KIND_READ:
            begin
                do_read = 1'b1;
            end
            KIND_WRITE:
            begin
                if (req.address < ADDR_PPU_BASE)
                begin
                    ram_we      = accept;
                    region_next = REGION_INTERNAL;
                end
                else if (req.address < ADDR_IO_BASE)
                begin
                    region_next    = REGION_PPU;
                    fwd_addr_next  = {13'd0, req.address[2:0]};
                    fwd_write_next = 1'b1;
                end
                else if (req.address == ADDR_OAM_DMA)
                begin
                    src_page_next  = req.data;
                    dma_index_next = 8'd0;
                    dma_on_next    = 1'b1;
                    dma_count_next = DMA_LEN + {{(DMA_CNT_W-1){1'b0}}, parity_reg};
                    region_next    = REGION_INTERNAL;
                end
                else if (req.address == ADDR_JOY1)
                begin
                    strobe_next = req.data[0];
                    // falling strobe latches the held buttons
                    if (strobe_reg && !req.data[0])
                    begin
                        shift0_next = buttons0_reg;
                        shift1_next = buttons1_reg;
                    end
                    region_next = REGION_INTERNAL;
                end
                else if (req.address < ADDR_IO_TEST)
                begin
                    region_next    = REGION_APU;
                    fwd_addr_next  = req.address;
                    fwd_write_next = 1'b1;
                end
                else if (req.address < ADDR_CART_BASE)
                begin
                    region_next = REGION_NONE;
                end
                else
                begin
                    region_next    = REGION_CART;
                    fwd_addr_next  = req.address;
                    fwd_write_next = 1'b1;
                end
            end
            KIND_BUTTONS:
            begin
                if (req.port)
                begin
                    buttons1_next = req.data;
                    if (strobe_reg)
                        shift1_next = req.data;
                end
                else
                begin
                    buttons0_next = req.data;
                    if (strobe_reg)
                        shift0_next = req.data;
                end
            end
            KIND_CYCLES:
            begin
                parity_next = parity_reg ^ req.cycles[0];
            end
            KIND_DMA:
            begin
                if (dma_on_reg)
                begin
                    if (dma_count_reg != '0)
                    begin
                        dma_count_next = cnt_dec;
                        // a byte moves on every nonzero even count
                        if (cnt_dec != '0 && !cnt_dec[0])
                        begin
                            do_read        = 1'b1;
                            rd_addr        = {src_page_reg, dma_index_reg};
                            oam_write_next = 1'b1;
                            oam_index_next = dma_index_reg;
                            dma_index_next = dma_index_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        dma_on_next = 1'b0;
                    end
                    parity_next = !parity_reg;
                end
            end
            default:
            begin
                region_next = REGION_NONE;
            end
        endcase

        // shared read decode for cpu reads and dma fetches
        if (do_read)
        begin
            if (rd_addr < ADDR_PPU_BASE)
            begin
                sel_ram_next = 1'b1;
                region_next  = REGION_INTERNAL;
            end
            else if (rd_addr < ADDR_IO_BASE)
            begin
                region_next   = REGION_PPU;
                fwd_addr_next = {13'd0, rd_addr[2:0]};
            end
            else if (rd_addr == ADDR_APU_STATUS)
            begin
                region_next   = REGION_APU;
                fwd_addr_next = rd_addr;
            end
            else if (rd_addr == ADDR_JOY1)
            begin
                rd_next     = {7'd0, shift0_reg[7]};
                shift0_next = {shift0_reg[6:0], 1'b0};
                region_next = REGION_INTERNAL;
            end
            else if (rd_addr == ADDR_JOY2)
            begin
                rd_next     = {7'd0, shift1_reg[7]};
                shift1_next = {shift1_reg[6:0], 1'b0};
                region_next = REGION_INTERNAL;
            end
            else if (rd_addr < ADDR_CART_BASE)
            begin
                region_next = REGION_NONE;
            end
            else
            begin
                region_next   = REGION_CART;
                fwd_addr_next = rd_addr;
            end
        end

        // the clearing pass owns the write port until it finishes
        if (clr_busy_reg)
        begin
            ram_we = 1'b1;
            ram_wa = clr_addr_reg;
            ram_wd = 8'd0;
        end
    end

    assign ram_re = accept && sel_ram_next;

    // work ram, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram[ram_wa] <= ram_wd;
        if (ram_re)
            ram_q_reg <= ram[rd_addr[RAM_AW-1:0]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            buttons0_reg  <= 8'd0;
            buttons1_reg  <= 8'd0;
            shift0_reg    <= 8'd0;
            shift1_reg    <= 8'd0;
            strobe_reg    <= 1'b0;
            dma_on_reg    <= 1'b0;
            src_page_reg  <= 8'd0;
            dma_index_reg <= 8'd0;
            dma_count_reg <= '0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + {{(RAM_AW-1){1'b0}}, 1'b1};
                if (clr_addr_reg == {RAM_AW{1'b1}})
                    clr_busy_reg <= 1'b0;
            end
            if (accept)
            begin
                buttons0_reg  <= buttons0_next;
                buttons1_reg  <= buttons1_next;
                shift0_reg    <= shift0_next;
                shift1_reg    <= shift1_next;
                strobe_reg    <= strobe_next;
                dma_on_reg    <= dma_on_next;
                src_page_reg  <= src_page_next;
                dma_index_reg <= dma_index_next;
                dma_count_reg <= dma_count_next;
                parity_reg    <= parity_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= rd_next;
            sel_ram_reg   <= sel_ram_next;
            region_reg    <= region_next;
            fwd_addr_reg  <= fwd_addr_next;
            fwd_write_reg <= fwd_write_next;
            oam_write_reg <= oam_write_next;
            oam_index_reg <= oam_index_next;
            busy_reg      <= dma_on_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = sel_ram_reg ? ram_q_reg : rd_reg;
    assign rsp.region    = region_reg;
    assign rsp.fwd_addr  = fwd_addr_reg;
    assign rsp.fwd_write = fwd_write_reg;
    assign rsp.oam_write = oam_write_reg;
    assign rsp.oam_index = oam_index_reg;
    assign rsp.dma_busy  = busy_reg;

endmodule

>>> hdl/cbd_checker.sv
// cbd_checker: port-level assertions for the console bus decoder core
// depends on cbd_pkg; bound to console_cpu_bus_decoder_dma_core below
module cbd_checker
    import cbd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [7:0]  read_data,
    input logic [2:0]  region,
    input logic [15:0] fwd_addr,
    input logic        fwd_write,
    input logic        oam_write,
    input logic        dma_busy
);

    // a stalled response word holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(region))
    else $error("stalled response word changed");

    // a sprite byte only moves while dma stays active
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && oam_write |-> dma_busy)
    else $error("oam write without dma busy");

    // nonzero data only comes from internal decode
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_data != 8'd0 |-> region == REGION_INTERNAL)
    else $error("read data outside internal region");

    // ppu accesses carry only the register number
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && region == REGION_PPU |-> fwd_addr[15:3] == 13'd0)
    else $error("ppu address not folded");

    // forwarded writes only go to external regions
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && fwd_write |->
            region == REGION_PPU || region == REGION_APU || region == REGION_CART)
    else $error("forwarded write to internal region");

endmodule

bind console_cpu_bus_decoder_dma_core cbd_checker u_cbd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .read_data (rsp.read_data),
    .region    (rsp.region),
    .fwd_addr  (rsp.fwd_addr),
    .fwd_write (rsp.fwd_write),
    .oam_write (rsp.oam_write),
    .dma_busy  (rsp.dma_busy)
);

>>> sim/tb.sv
// tb: self-checking bench for console_cpu_bus_decoder_dma_core
// depends on cbd_pkg, the channel interfaces in cbd_if.sv and the core itself
`timescale 1ns / 100ps

module tb;
    import cbd_pkg::*;

    // kinds the core must ignore
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    // run limits: worst case is ~750 words plus the ram clear
    localparam int CYCLE_LIMIT = 300000;
    localparam int TOTAL_WORDS = 650;
    localparam int PRINT_CAP = 40;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic        port;
        logic [3:0]  cycles;
    } bus_word_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [2:0]  region;
        logic [15:0] fwd_addr;
        logic        fwd_write;
        logic        oam_write;
        logic [7:0]  oam_index;
        logic        dma_busy;
    } bus_result_t;

    // one row of stimulus; typed rows carry their expected word
    typedef struct packed {
        bus_word_t   w;
        logic        typed;
        bus_result_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    cbd_req_if req_ch ();
    cbd_rsp_if rsp_ch ();

    console_cpu_bus_decoder_dma_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow state of the bus decoder, same reset values as the core
    // ------------------------------------------------------------------
    logic [7:0] ram_shadow [RAM_DEPTH];
    logic [7:0] held_buttons [2];
    logic [7:0] pad_shift [2];
    logic       strobe_shadow;
    logic       sprite_busy;
    logic [7:0] sprite_page;
    logic [7:0] dma_ptr;
    logic [DMA_CNT_W-1:0] dma_left;
    logic       parity_shadow;

    stim_row_t   stim_rows [$];
    bus_result_t pending_results [$];
    int          mismatch_count = 0;
    int          result_index = 0;
    int          cycle_count = 0;

    initial
    begin
        for (int i = 0; i < RAM_DEPTH; i++)
            ram_shadow[i] = 8'h00;
        held_buttons[0] = 8'h00;
        held_buttons[1] = 8'h00;
        pad_shift[0] = 8'h00;
        pad_shift[1] = 8'h00;
        strobe_shadow = 1'b0;
        sprite_busy = 1'b0;
        sprite_page = 8'h00;
        dma_ptr = 8'h00;
        dma_left = '0;
        parity_shadow = 1'b0;
    end

    // read side of the decode, including the controller shift side effect
    function automatic bus_result_t decode_read(input logic [15:0] a);
        bus_result_t r;
        r = '0;
        r.region = REGION_NONE;
        if (a < ADDR_PPU_BASE)
        begin
            r.read_data = ram_shadow[a[RAM_AW-1:0]];
            r.region = REGION_INTERNAL;
        end
        else if (a < ADDR_IO_BASE)
        begin
            r.region = REGION_PPU;
            r.fwd_addr = {13'd0, a[2:0]};
        end
        else if (a == ADDR_APU_STATUS)
        begin
            r.region = REGION_APU;
            r.fwd_addr = a;
        end
        else if (a == ADDR_JOY1 || a == ADDR_JOY2)
        begin
            // serial bit is the msb, zero shifts in from below
            r.read_data = {7'd0, pad_shift[a[0]][7]};
            pad_shift[a[0]] = {pad_shift[a[0]][6:0], 1'b0};
            r.region = REGION_INTERNAL;
        end
        else if (a >= ADDR_CART_BASE)
        begin
            r.region = REGION_CART;
            r.fwd_addr = a;
        end
        return r;
    endfunction

    function automatic bus_result_t decode_write(input logic [15:0] a, input logic [7:0] v);
        bus_result_t r;
        logic        old_strobe;
        r = '0;
        r.region = REGION_NONE;
        if (a < ADDR_PPU_BASE)
        begin
            ram_shadow[a[RAM_AW-1:0]] = v;
            r.region = REGION_INTERNAL;
        end
        else if (a < ADDR_IO_BASE)
        begin
            r.region = REGION_PPU;
            r.fwd_addr = {13'd0, a[2:0]};
            r.fwd_write = 1'b1;
        end
        else if (a == ADDR_OAM_DMA)
        begin
            // (re)start sprite dma; odd parity lengthens it by the parity bit
            sprite_page = v;
            dma_ptr = 8'h00;
            sprite_busy = 1'b1;
            dma_left = DMA_LEN + {9'd0, parity_shadow};
            r.region = REGION_INTERNAL;
        end
        else if (a == ADDR_JOY1)
        begin
            old_strobe = strobe_shadow;
            strobe_shadow = v[0];
            if (old_strobe && !strobe_shadow)
            begin
                pad_shift[0] = held_buttons[0];
                pad_shift[1] = held_buttons[1];
            end
            r.region = REGION_INTERNAL;
        end
        else if (a < ADDR_IO_TEST)
        begin
            r.region = REGION_APU;
            r.fwd_addr = a;
            r.fwd_write = 1'b1;
        end
        else if (a >= ADDR_CART_BASE)
        begin
            r.region = REGION_CART;
            r.fwd_addr = a;
            r.fwd_write = 1'b1;
        end
        return r;
    endfunction

    // full prediction of one accepted request word
    function automatic bus_result_t predict_bus_word(input bus_word_t w);
        bus_result_t r;
        r = '0;
        r.region = REGION_NONE;
        case (w.kind)
            KIND_READ:    r = decode_read(w.address);
            KIND_WRITE:   r = decode_write(w.address, w.data);
            KIND_BUTTONS:
            begin
                held_buttons[w.port] = w.data;
                if (strobe_shadow)
                    pad_shift[w.port] = w.data;
            end
            KIND_CYCLES:  parity_shadow = parity_shadow ^ w.cycles[0];
            KIND_DMA:
            begin
                // idle dma cycles do nothing, not even parity
                if (sprite_busy)
                begin
                    if (dma_left != '0)
                    begin
                        dma_left = dma_left - 1'b1;
                        // even nonzero counts move one byte
                        if (dma_left != '0 && !dma_left[0])
                        begin
                            r = decode_read({sprite_page, dma_ptr});
                            r.oam_write = 1'b1;
                            r.oam_index = dma_ptr;
                            dma_ptr = dma_ptr + 8'd1;
                        end
                    end
                    else
                        sprite_busy = 1'b0;
                    parity_shadow = ~parity_shadow;
                end
            end
            default: ;
        endcase
        r.dma_busy = sprite_busy;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus table
    // ------------------------------------------------------------------
    task automatic add_word(input logic [2:0] k, input logic [15:0] a, input logic [7:0] d,
                            input logic p, input logic [3:0] c);
        stim_row_t row;
        row = '0;
        row.w = '{kind: k, address: a, data: d, port: p, cycles: c};
        stim_rows.push_back(row);
    endtask

    task automatic add_checked_word(input logic [2:0] k, input logic [15:0] a,
                                    input logic [7:0] d, input logic p, input logic [3:0] c,
                                    input logic [7:0] rd, input logic [2:0] region,
                                    input logic [15:0] fwd, input logic fw, input logic busy);
        stim_row_t row;
        row = '0;
        row.w = '{kind: k, address: a, data: d, port: p, cycles: c};
        row.typed = 1'b1;
        row.res.read_data = rd;
        row.res.region = region;
        row.res.fwd_addr = fwd;
        row.res.fwd_write = fw;
        row.res.dma_busy = busy;
        stim_rows.push_back(row);
    endtask

    task automatic build_directed_part();
        // ram after reset, top of ram and its mirror at the top of the window
        add_checked_word(KIND_READ, 16'h0000, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_INTERNAL, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, 16'h07FF, 8'hFF, 1'b1, 4'd15,
                         8'h00, REGION_INTERNAL, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_READ, 16'h1FFF, 8'h00, 1'b0, 4'd0,
                         8'hFF, REGION_INTERNAL, 16'h0000, 1'b0, 1'b0);
        // ppu window edges, address folds to 3 bits
        add_checked_word(KIND_READ, ADDR_PPU_BASE, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_PPU, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, 16'h3FFF, 8'hA5, 1'b0, 4'd0,
                         8'h00, REGION_PPU, 16'h0007, 1'b1, 1'b0);
        // apu status read, apu register write
        add_checked_word(KIND_READ, ADDR_APU_STATUS, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_APU, ADDR_APU_STATUS, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, ADDR_IO_BASE, 8'h5A, 1'b0, 4'd0,
                         8'h00, REGION_APU, ADDR_IO_BASE, 1'b1, 1'b0);
        // unused io space: reads give zero, writes are dropped
        add_checked_word(KIND_READ, ADDR_OAM_DMA, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, ADDR_IO_TEST, 8'h33, 1'b0, 4'd0,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, 16'h401F, 8'hCC, 1'b0, 4'd0,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        // cartridge space edges
        add_checked_word(KIND_READ, 16'hFFFF, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_CART, 16'hFFFF, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, ADDR_CART_BASE, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_CART, ADDR_CART_BASE, 1'b1, 1'b0);
        // controller: load buttons, strobe high, reload while high, falling edge, read both ports
        add_checked_word(KIND_BUTTONS, 16'h0000, 8'h81, 1'b0, 4'd0,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_BUTTONS, 16'hFFFF, 8'h7E, 1'b1, 4'd0,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_WRITE, ADDR_JOY1, 8'h01, 1'b0, 4'd0,
                         8'h00, REGION_INTERNAL, 16'h0000, 1'b0, 1'b0);
        add_word(KIND_BUTTONS, 16'h0000, 8'hC3, 1'b0, 4'd0);
        add_word(KIND_WRITE, ADDR_JOY1, 8'hFE, 1'b0, 4'd0);
        add_word(KIND_READ, ADDR_JOY1, 8'h00, 1'b0, 4'd0);
        add_word(KIND_READ, ADDR_JOY2, 8'h00, 1'b0, 4'd0);
        // odd cycle count flips parity, so the dma below is the long one
        add_checked_word(KIND_CYCLES, 16'h0000, 8'h00, 1'b0, 4'd15,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        // dma cycle with no dma running, and the spare kinds
        add_checked_word(KIND_DMA, 16'h0000, 8'h00, 1'b0, 4'd0,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_SPARE_A, 16'h0000, 8'hFF, 1'b1, 4'd15,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        add_checked_word(KIND_SPARE_C, 16'h1234, 8'h00, 1'b0, 4'd1,
                         8'h00, REGION_NONE, 16'h0000, 1'b0, 1'b0);
        // start dma from page 7, one dma cycle, then a ram access during dma
        add_checked_word(KIND_WRITE, ADDR_OAM_DMA, 8'h07, 1'b0, 4'd0,
                         8'h00, REGION_INTERNAL, 16'h0000, 1'b0, 1'b1);
        add_word(KIND_DMA, 16'h0000, 8'h00, 1'b0, 4'd0);
        add_word(KIND_READ, 16'h0800, 8'h00, 1'b0, 4'd0);
    endtask

    // random part: well-formed ram, controller, dma and ppu/io sequences plus noise
    task automatic build_random_part();
        int          n;
        int          seg;
        bit          want_full;
        bit          first_dma;
        logic [10:0] ram_base;
        logic [7:0]  page;
        logic [15:0] a;
        first_dma = 1'b1;
        while (stim_rows.size() < TOTAL_WORDS)
        begin
            // the long dma run comes first so the word count stays near the target
            seg = first_dma ? 3 : $urandom_range(0, 5);
            case (seg)
                0, 1:
                begin
                    // ram traffic in a small window, through all four mirrors
                    ram_base = 11'($urandom);
                    n = $urandom_range(4, 14);
                    for (int k = 0; k < n; k++)
                    begin
                        a = {3'b000, 2'($urandom_range(0, 3)),
                             11'(ram_base + 11'($urandom_range(0, 15)))};
                        add_word($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, a,
                                 8'($urandom), 1'($urandom), 4'($urandom));
                    end
                end
                2:
                begin
                    // controller poll: load, strobe, maybe reload, maybe latch, shift out
                    add_word(KIND_BUTTONS, 16'($urandom), 8'($urandom), 1'b0, 4'($urandom));
                    add_word(KIND_BUTTONS, 16'($urandom), 8'($urandom), 1'b1, 4'($urandom));
                    add_word(KIND_WRITE, ADDR_JOY1, {7'($urandom), 1'b1}, 1'($urandom),
                             4'($urandom));
                    if ($urandom_range(0, 1))
                        add_word(KIND_BUTTONS, 16'($urandom), 8'($urandom), 1'($urandom),
                                 4'($urandom));
                    if ($urandom_range(0, 3) != 0)
                        add_word(KIND_WRITE, ADDR_JOY1, {7'($urandom), 1'b0},
                                 1'($urandom), 4'($urandom));
                    n = $urandom_range(6, 10);
                    for (int k = 0; k < n; k++)
                        add_word(KIND_READ, ADDR_JOY1 + 16'($urandom_range(0, 1)),
                                 8'($urandom), 1'($urandom), 4'($urandom));
                end
                3:
                begin
                    // sprite dma; the first run goes to the end
                    want_full = first_dma;
                    first_dma = 1'b0;
                    add_word(KIND_CYCLES, 16'($urandom), 8'($urandom), 1'($urandom),
                             4'($urandom));
                    case ($urandom_range(0, 3))
                        0:       page = 8'($urandom_range(0, 8'h1F));
                        1:       page = 8'h40;
                        2:       page = 8'($urandom_range(8'h20, 8'h3F));
                        default: page = 8'($urandom);
                    endcase
                    add_word(KIND_WRITE, ADDR_OAM_DMA, page, 1'($urandom), 4'($urandom));
                    n = want_full ? 515 + $urandom_range(0, 5) : $urandom_range(1, 60);
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            case ($urandom_range(0, 2))
                                0:       a = 16'($urandom_range(0, 16'h1FFF));
                                1:       a = ADDR_JOY1 + 16'($urandom_range(0, 1));
                                default: a = 16'($urandom);
                            endcase
                            add_word(3'($urandom_range(0, 2)), a, 8'($urandom),
                                     1'($urandom), 4'($urandom));
                        end
                        add_word(KIND_DMA, 16'($urandom), 8'($urandom), 1'($urandom),
                                 4'($urandom));
                    end
                end
                4:
                begin
                    // ppu and io window traffic
                    n = $urandom_range(2, 8);
                    for (int k = 0; k < n; k++)
                    begin
                        if ($urandom_range(0, 1))
                            a = 16'($urandom_range(16'h2000, 16'h3FFF));
                        else
                            a = 16'($urandom_range(16'h4000, 16'h4027));
                        add_word($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, a,
                                 8'($urandom), 1'($urandom), 4'($urandom));
                    end
                end
                default:
                begin
                    // noise: any kind, any field
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        add_word(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom),
                                 1'($urandom), 4'($urandom));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // request side: reset, then walk the table with random gaps
    // ------------------------------------------------------------------
    initial
    begin
        int          gap;
        bit          src_burst;
        bus_result_t predicted;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_READ;
        req_ch.address = 16'h0000;
        req_ch.data = 8'h00;
        req_ch.port = 1'b0;
        req_ch.cycles = 4'd0;
        src_burst = 1'b0;
        build_directed_part();
        build_random_part();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            // occasionally switch between gappy traffic and back-to-back words
            if ($urandom_range(0, 31) == 0)
                src_burst = !src_burst;
            gap = src_burst ? 0 : $urandom_range(0, 9);
            repeat (gap)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
            end
            @(negedge clk);
            req_ch.valid <= 1'b1;
            req_ch.kind <= stim_rows[i].w.kind;
            req_ch.address <= stim_rows[i].w.address;
            req_ch.data <= stim_rows[i].w.data;
            req_ch.port <= stim_rows[i].w.port;
            req_ch.cycles <= stim_rows[i].w.cycles;
            // ready is low through the ram clear after reset
            do
                @(posedge clk);
            while (!req_ch.ready);
            // predictor always runs so the shadow state stays in step
            predicted = predict_bus_word(stim_rows[i].w);
            pending_results.push_back(stim_rows[i].typed ? stim_rows[i].res : predicted);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // wait DRAIN_CYCLES more so a stray extra word would show up
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[console_cpu_bus_decoder_dma_core] OK");
        else
            $display("[console_cpu_bus_decoder_dma_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // response side: random stalls, with bursts of no stall
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        bit sink_burst;
        rsp_ch.ready = 1'b0;
        sink_burst = 1'b0;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 9);
            repeat (stall)
            begin
                @(negedge clk);
                rsp_ch.ready <= 1'b0;
            end
            @(negedge clk);
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rsp_ch.valid);
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch on word %0d, %s: got %h want %h", result_index, what, got, want);
    endtask

    // compare each accepted response word against the oldest prediction
    always @(posedge clk)
    begin
        bus_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", {8'h00, rsp_ch.read_data}, 16'h0000);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.read_data !== want.read_data)
                    report_mismatch("read_data", {8'h00, rsp_ch.read_data}, {8'h00, want.read_data});
                if (rsp_ch.region !== want.region)
                    report_mismatch("region", {13'd0, rsp_ch.region}, {13'd0, want.region});
                if (rsp_ch.fwd_addr !== want.fwd_addr)
                    report_mismatch("fwd_addr", rsp_ch.fwd_addr, want.fwd_addr);
                if (rsp_ch.fwd_write !== want.fwd_write)
                    report_mismatch("fwd_write", {15'd0, rsp_ch.fwd_write}, {15'd0, want.fwd_write});
                if (rsp_ch.oam_write !== want.oam_write)
                    report_mismatch("oam_write", {15'd0, rsp_ch.oam_write}, {15'd0, want.oam_write});
                if (rsp_ch.oam_index !== want.oam_index)
                    report_mismatch("oam_index", {8'h00, rsp_ch.oam_index}, {8'h00, want.oam_index});
                if (rsp_ch.dma_busy !== want.dma_busy)
                    report_mismatch("dma_busy", {15'd0, rsp_ch.dma_busy}, {15'd0, want.dma_busy});
            end
            result_index++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[console_cpu_bus_decoder_dma_core] ERROR");
            $finish;
        end
    end

endmodule

>>> console_cpu_bus_decoder_dma_core.f
hdl/cbd_pkg.sv
hdl/cbd_if.sv
hdl/console_cpu_bus_decoder_dma_core.sv
hdl/cbd_checker.sv
sim/tb.sv
